### design/sme_pkg.sv
// Shared types and constants for the small matrix engine.
// No dependencies; imported by every module of the block except sme_ram.

package sme_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = 4;

   typedef enum logic [2:0] {
      CMD_LOAD_A = 3'd0,
      CMD_LOAD_B = 3'd1,
      CMD_ADD    = 3'd2,
      CMD_EMUL   = 3'd3,
      CMD_MMUL   = 3'd4
   } cmd_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // one issued product/sum term travelling down the datapath
   typedef struct packed {
      logic             valid;
      logic             mul;
      logic             first;
      logic             endk;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } sme_tag_type;

endpackage

### design/sme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sme_store.sv
// One operand matrix: RAM plus per-entry valid bits so unwritten entries read as zero.
// Depends on sme_pkg and sme_ram.

module sme_store import sme_pkg::*; #(
   parameter int MAX_DIM = 8,
   localparam int DEPTH = MAX_DIM * MAX_DIM,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic              rd_valid_ff;
   logic              rd_valid_in;
   logic [DATA_W-1:0] ram_data;

   sme_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? ram_data : '0;

endmodule

### design/sme_seq.sv
// Address sequencer: walks rows, columns and the inner k index of a compute word.
// Depends on sme_pkg.

module sme_seq import sme_pkg::*; #(
   parameter int MAX_DIM = 8,
   localparam int IW = $clog2(MAX_DIM),
   localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             start_mm,
   input  logic             start_mul,
   input  logic [CNT_W-1:0] nr,
   input  logic [CNT_W-1:0] nc,
   input  logic             adv,
   output logic             busy,
   output logic [AW-1:0]    rd_addr_a,
   output logic [AW-1:0]    rd_addr_b,
   output sme_tag_type      issue
);

   seq_state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] k_ff, k_in;
   logic          mm_ff, mm_in;
   logic          mul_ff, mul_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      mm_ff  <= mm_in;
      mul_ff <= mul_in;
   end

   always_comb begin
      logic i_end, j_end, k_end;
      i_end = (CNT_W'(i_ff) == nr - CNT_W'(1));
      j_end = (CNT_W'(j_ff) == nc - CNT_W'(1));
      k_end = !mm_ff || (CNT_W'(k_ff) == nr - CNT_W'(1));

      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      mm_in    = mm_ff;
      mul_in   = mul_ff;

      issue.valid = 1'b0;
      issue.mul   = mul_ff;
      issue.first = !mm_ff || (k_ff == '0);
      issue.endk  = k_end;
      issue.last  = k_end && i_end && j_end;
      issue.row   = IDX_W'(i_ff);
      issue.col   = IDX_W'(j_ff);

      if (mm_ff) begin
         rd_addr_a = AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff);
         rd_addr_b = AW'(k_ff) * AW'(MAX_DIM) + AW'(j_ff);
      end else begin
         rd_addr_a = AW'(i_ff) * AW'(MAX_DIM) + AW'(j_ff);
         rd_addr_b = rd_addr_a;
      end

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               mm_in    = start_mm;
               mul_in   = start_mul;
            end
         end
         SEQ_RUN: begin
            if (adv) begin
               issue.valid = 1'b1;
               if (!k_end) begin
                  k_in = k_ff + IW'(1);
               end else begin
                  k_in = '0;
                  if (j_end) begin
                     j_in = '0;
                     if (i_end) begin
                        state_in = SEQ_IDLE;
                     end else begin
                        i_in = i_ff + IW'(1);
                     end
                  end else begin
                     j_in = j_ff + IW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == SEQ_RUN);

endmodule

### design/sme_dpath.sv
// Arithmetic pipeline: sum or product of the read operands, accumulate, output register.
// Depends on sme_pkg.

module sme_dpath import sme_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  sme_tag_type              issue,
   input  logic [DATA_W-1:0]        a_data,
   input  logic [DATA_W-1:0]        b_data,
   output logic                     adv,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_last
);

   sme_tag_type       s1_ff, s1_in;
   sme_tag_type       s2_ff, s2_in;
   logic [DATA_W-1:0] term_ff, term_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] total;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              last_ff, last_in;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign total = (s2_ff.first ? '0 : acc_ff) + term_ff;

   always_comb begin
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      if (adv) begin
         s1_in        = issue;
         s2_in        = s1_ff;
         term_in      = s1_ff.mul ? a_data * b_data : a_data + b_data;
         rsp_valid_in = s2_ff.valid && s2_ff.endk;
         if (s2_ff.valid) begin
            acc_in  = total;
            row_in  = s2_ff.row;
            col_in  = s2_ff.col;
            res_in  = total;
            last_in = s2_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      acc_ff  <= acc_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign busy        = s1_ff.valid || s2_ff.valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = row_ff;
   assign rsp_out_col = col_ff;
   assign rsp_result  = res_ff;
   assign rsp_last    = last_ff;

endmodule

### design/small_matrix_engine.sv
// Top level of the small matrix engine: CSR port, operand stores, sequencer, datapath.
// Depends on sme_pkg, sme_store, sme_seq and sme_dpath.
//
//   channel | signals                                    | moves
//   req     | req_valid/req_ready, cmd row col value     | one command word
//   rsp     | rsp_valid/rsp_ready, out_row out_col ...   | one result element word
//   csr     | psel penable pwrite paddr pwdata prdata    | row_count, col_count
//
// Add and element-wise multiply stream one element per cycle while rsp is not stalled.
// Matrix multiply reads one A and one B element per cycle, also while rsp is not stalled,
// through the single read port of each store, so each result element sums row_count
// products. A stalled rsp side freezes the whole pipeline. Reset sets both counts to 1 and
// marks every store entry unwritten (reads as zero); no clearing pass is needed.

module small_matrix_engine import sme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_row,
   input  logic [IDX_W-1:0]         req_col,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int IW = $clog2(MAX_DIM);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [CNT_W-1:0]  col_count_ff, col_count_in;
   logic [CNT_W-1:0]  nr, nc;
   logic              csr_wr;
   logic              accept;
   logic              in_range;
   logic              a_we, b_we;
   logic [AW-1:0]     ld_addr;
   logic              start;
   logic              adv;
   logic              seq_busy, dp_busy;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] a_data, b_data;
   sme_tag_type       issue;

   // CSR
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? 32'(col_count_ff) : 32'(row_count_ff);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_wr) begin
         if (csr_paddr[2]) begin
            col_count_in = csr_pwdata[CNT_W-1:0];
         end else begin
            row_count_in = csr_pwdata[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CNT_W'(1);
         col_count_ff <= CNT_W'(1);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // zero counts act as 1, large counts as MAX_DIM
   assign nr = (row_count_ff == '0) ? CNT_W'(1) :
               (row_count_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : row_count_ff;
   assign nc = (col_count_ff == '0) ? CNT_W'(1) :
               (col_count_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : col_count_ff;

   // command decode
   assign req_ready = !seq_busy && !dp_busy;
   assign accept    = req_valid && req_ready;
   assign in_range  = (CNT_W'(req_row) < CNT_W'(MAX_DIM)) &&
                      (CNT_W'(req_col) < CNT_W'(MAX_DIM));
   assign a_we      = accept && in_range && (req_cmd == CMD_LOAD_A);
   assign b_we      = accept && in_range && (req_cmd == CMD_LOAD_B);
   assign ld_addr   = AW'(req_row[IW-1:0]) * AW'(MAX_DIM) + AW'(req_col[IW-1:0]);
   assign start     = accept && ((req_cmd == CMD_ADD) || (req_cmd == CMD_EMUL) ||
                                 (req_cmd == CMD_MMUL));

   sme_store #(.MAX_DIM(MAX_DIM)) u_store_a (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (a_we),
      .wr_addr(ld_addr),
      .wr_data(req_value),
      .rd_en  (adv),
      .rd_addr(rd_addr_a),
      .rd_data(a_data)
   );

   sme_store #(.MAX_DIM(MAX_DIM)) u_store_b (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (b_we),
      .wr_addr(ld_addr),
      .wr_data(req_value),
      .rd_en  (adv),
      .rd_addr(rd_addr_b),
      .rd_data(b_data)
   );

   sme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .start_mm (req_cmd == CMD_MMUL),
      .start_mul(req_cmd != CMD_ADD),
      .nr       (nr),
      .nc       (nc),
      .adv      (adv),
      .busy     (seq_busy),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .issue    (issue)
   );

   sme_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .a_data     (a_data),
      .b_data     (b_data),
      .adv        (adv),
      .busy       (dp_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last)
   );

   // store writes never overlap operand reads of a compute word
   a_store_wr_idle: assert property (@(posedge clock) disable iff (reset)
      (a_we || b_we) |-> (!seq_busy && !dp_busy))
      else $error("store written while compute in flight");

   // the final term issued ends the sweep
   a_last_ends_seq: assert property (@(posedge clock) disable iff (reset)
      (issue.valid && issue.last) |=> !seq_busy)
      else $error("sequencer still running after final term");

   // results stay inside the area in use
   a_rsp_in_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CNT_W'(rsp_out_row) < nr) && (CNT_W'(rsp_out_col) < nc)))
      else $error("result coordinates outside row/col counts");

endmodule
